>>> rtl/tslb_pkg.sv
// Shared types and constants for the terminal scrollback line buffer.
package tslb_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int ENTRY_W        = 16;   // {char, cell width}

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_ENTER = 3'd2;
    localparam logic [2:0] OP_WEND  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [6:0] TAB_CELLS  = 7'd4;
    localparam logic [6:0] WIDTH_RST  = 7'd80;
    localparam logic [7:0] HEIGHT_RST = 8'd25;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_code;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  read_char;
        logic        read_valid;
        logic        read_newline;
        logic [11:0] draw_start;
        logic [11:0] cursor_index;
        logic [7:0]  line_count;
        logic [6:0]  line_fill;
    } t_result;

endpackage

>>> rtl/tslb_ram.sv
// Generic simple dual-port RAM with registered read.
module tslb_ram #(
    parameter int WIDTH = tslb_pkg::ENTRY_W,
    parameter int DEPTH = tslb_pkg::RING_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/terminal_scrollback_line_buffer_core.sv
// Top level: scrollback ring controller around one character/width RAM.
// Push w/o scroll, write end, empty read, no-op and blocked pop finish from S_IDLE;
// read passes S_RD_WAIT and pop S_POP_WAIT. A push that scrolls walks stored widths
// through S_SCR/S_SCR_ACC; a pop that unwraps a line walks back via S_UNW/S_UNW_ACC.
// busy is high outside S_IDLE and start is taken only in S_IDLE; results cannot be stalled.
// Sync reset clears pointers, lines=1, cells=0, 80x25 screen; RAM is not cleared.
module terminal_scrollback_line_buffer_core #(
    parameter int RING_DEPTH = tslb_pkg::RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tslb_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output tslb_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam logic [IW-1:0] LAST = IW'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_POP_WAIT,
        S_UNW,
        S_UNW_ACC,
        S_SCR,
        S_SCR_ACC
    } t_state;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] i);
        f_next = (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] i);
        f_prev = (i == '0) ? LAST : i - 1'b1;
    endfunction

    t_state            r_state, n_state;
    logic [6:0]        r_scr_w, n_scr_w;
    logic [7:0]        r_scr_h, n_scr_h;
    logic [IW-1:0]     r_oldest, n_oldest;
    logic [IW-1:0]     r_draw, n_draw;
    logic [IW-1:0]     r_unread, n_unread;
    logic [IW-1:0]     r_edit, n_edit;
    logic [IW-1:0]     r_write, n_write;
    logic [7:0]        r_lines, n_lines;
    logic [6:0]        r_cells, n_cells;
    logic [IW-1:0]     r_walk, n_walk;
    logic [7:0]        r_sum, n_sum;
    logic [6:0]        r_steps, n_steps;
    logic              r_done, n_done;
    tslb_pkg::t_result r_res, n_res;

    logic [6:0]        w_eff;
    logic [7:0]        h_eff;
    logic [7:0]        push_chr;
    logic [6:0]        size;
    logic [7:0]        size_sum;
    logic [6:0]        cw;
    logic [6:0]        cells_add;
    logic [8:0]        lines_inc;
    logic [IW-1:0]     wr_nx, wr_pv, old_nx, walk_pv;
    logic [7:0]        rd_w;
    logic              fin;
    logic [7:0]        rc;
    logic              rv, rn;

    logic                      mem_we;
    logic [IW-1:0]             mem_waddr, mem_raddr;
    logic [tslb_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

    tslb_ram #(
        .WIDTH(tslb_pkg::ENTRY_W),
        .DEPTH(RING_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // zero in a screen register acts as one
    assign w_eff     = (r_scr_w == '0) ? 7'd1 : r_scr_w;
    assign h_eff     = (r_scr_h == '0) ? 8'd1 : r_scr_h;
    assign push_chr  = (i_cmd.op == tslb_pkg::OP_ENTER) ? tslb_pkg::CHAR_NL : i_cmd.char_code;
    assign size      = (push_chr == tslb_pkg::CHAR_NL)  ? w_eff :
                       (push_chr == tslb_pkg::CHAR_TAB) ? tslb_pkg::TAB_CELLS : 7'd1;
    assign size_sum  = {1'b0, size} + {1'b0, r_cells};
    // clip to line end; an overfull line (width lowered) gives zero cells
    assign cw        = (r_cells >= w_eff)             ? 7'd0 :
                       (size_sum > {1'b0, w_eff})     ? w_eff - r_cells : size;
    assign cells_add = r_cells + cw;
    assign lines_inc = {1'b0, r_lines} + 9'd1;
    assign wr_nx     = f_next(r_write);
    assign wr_pv     = f_prev(r_write);
    assign old_nx    = f_next(r_oldest);
    assign walk_pv   = f_prev(r_walk);
    assign rd_w      = mem_rdata[7:0];

    always_comb begin
        n_state  = r_state;
        n_scr_w  = r_scr_w;
        n_scr_h  = r_scr_h;
        n_oldest = r_oldest;
        n_draw   = r_draw;
        n_unread = r_unread;
        n_edit   = r_edit;
        n_write  = r_write;
        n_lines  = r_lines;
        n_cells  = r_cells;
        n_walk   = r_walk;
        n_sum    = r_sum;
        n_steps  = r_steps;
        n_done   = 1'b0;
        n_res    = r_res;
        fin      = 1'b0;
        rc       = '0;
        rv       = 1'b0;
        rn       = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_write;
        mem_wdata = {push_chr, 1'b0, cw};
        mem_raddr = r_draw;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tslb_pkg::CFG_SCREEN_WIDTH:  n_scr_w = i_cfg_data[6:0];
                tslb_pkg::CFG_SCREEN_HEIGHT: n_scr_h = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                mem_raddr = (i_cmd.op == tslb_pkg::OP_POP) ? wr_pv : r_unread;
                if (start) begin
                    unique case (i_cmd.op) inside
                        tslb_pkg::OP_PUSH, tslb_pkg::OP_ENTER: begin
                            mem_we   = 1'b1;
                            n_write  = wr_nx;
                            n_oldest = (wr_nx == r_oldest) ? old_nx : r_oldest;
                            n_unread = (wr_nx == r_unread) ? n_oldest : r_unread;
                            if (i_cmd.op == tslb_pkg::OP_ENTER) begin
                                n_edit = wr_nx;
                            end else if (wr_nx == r_edit) begin
                                n_edit = n_oldest;
                            end
                            n_cells = cells_add;
                            if (cells_add >= w_eff) begin
                                n_cells = '0;
                                if (lines_inc > {1'b0, h_eff}) begin
                                    n_sum   = '0;
                                    n_steps = '0;
                                    n_state = S_SCR;
                                end else begin
                                    n_lines = lines_inc[7:0];
                                    fin     = 1'b1;
                                end
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        tslb_pkg::OP_POP: begin
                            if (r_write == r_edit) begin
                                fin = 1'b1;
                            end else begin
                                n_write = wr_pv;
                                n_state = S_POP_WAIT;
                            end
                        end
                        tslb_pkg::OP_WEND: begin
                            n_unread = r_write;
                            n_edit   = r_write;
                            fin      = 1'b1;
                        end
                        tslb_pkg::OP_READ: begin
                            if (r_unread != r_edit) begin
                                n_state = S_RD_WAIT;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            S_RD_WAIT: begin
                rc       = mem_rdata[15:8];
                rv       = 1'b1;
                rn       = (mem_rdata[15:8] == tslb_pkg::CHAR_NL);
                n_unread = f_next(r_unread);
                fin      = 1'b1;
            end
            S_POP_WAIT: begin
                if (r_cells == '0) begin
                    n_cells = (rd_w <= {1'b0, w_eff}) ? w_eff - rd_w[6:0] : '0;
                    if (r_lines == h_eff) begin
                        n_walk  = r_draw;
                        n_sum   = '0;
                        n_steps = '0;
                        n_state = S_UNW;
                    end else begin
                        if (r_lines != '0) begin
                            n_lines = r_lines - 8'd1;
                        end
                        fin = 1'b1;
                    end
                end else begin
                    n_cells = ({1'b0, r_cells} >= rd_w) ? r_cells - rd_w[6:0] : '0;
                    fin     = 1'b1;
                end
            end
            S_UNW: begin
                // walk back from draw start looking for one exact screen line
                mem_raddr = walk_pv;
                if (r_sum < {1'b0, w_eff} && r_steps < w_eff && r_walk != r_oldest) begin
                    n_walk  = walk_pv;
                    n_state = S_UNW_ACC;
                end else begin
                    if (r_sum == {1'b0, w_eff}) begin
                        n_draw = r_walk;
                    end else if (r_lines != '0) begin
                        n_lines = r_lines - 8'd1;
                    end
                    fin = 1'b1;
                end
            end
            S_UNW_ACC: begin
                n_sum   = r_sum + rd_w;
                n_steps = r_steps + 7'd1;
                n_state = S_UNW;
            end
            S_SCR: begin
                mem_raddr = r_draw;
                if (r_sum < {1'b0, w_eff} && r_steps < w_eff && r_draw != r_write) begin
                    n_state = S_SCR_ACC;
                end else begin
                    fin = 1'b1;
                end
            end
            S_SCR_ACC: begin
                n_sum   = r_sum + rd_w;
                n_draw  = f_next(r_draw);
                n_steps = r_steps + 7'd1;
                n_state = S_SCR;
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            n_state              = S_IDLE;
            n_done               = 1'b1;
            n_res.read_char      = rc;
            n_res.read_valid     = rv;
            n_res.read_newline   = rn;
            n_res.draw_start     = 12'(n_draw);
            n_res.cursor_index   = 12'(n_write);
            n_res.line_count     = n_lines;
            n_res.line_fill      = n_cells;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scr_w  <= tslb_pkg::WIDTH_RST;
            r_scr_h  <= tslb_pkg::HEIGHT_RST;
            r_oldest <= '0;
            r_draw   <= '0;
            r_unread <= '0;
            r_edit   <= '0;
            r_write  <= '0;
            r_lines  <= 8'd1;
            r_cells  <= '0;
            r_walk   <= '0;
            r_sum    <= '0;
            r_steps  <= '0;
            r_done   <= 1'b0;
            r_res    <= '0;
        end else begin
            r_state  <= n_state;
            r_scr_w  <= n_scr_w;
            r_scr_h  <= n_scr_h;
            r_oldest <= n_oldest;
            r_draw   <= n_draw;
            r_unread <= n_unread;
            r_edit   <= n_edit;
            r_write  <= n_write;
            r_lines  <= n_lines;
            r_cells  <= n_cells;
            r_walk   <= n_walk;
            r_sum    <= n_sum;
            r_steps  <= n_steps;
            r_done   <= n_done;
            r_res    <= n_res;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word shown while a walk is still running");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted word neither finished nor started a walk");

    a_newline_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.read_newline) |-> o_result.read_valid)
        else $error("newline flag without a read character");

    a_unread_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_state != S_RD_WAIT) |=> $stable(r_unread))
        else $error("unread start moved during a walk");
`endif

endmodule
